// File: sv/advert_replay_filter_core_macros.svh
// Assertion macros shared by the advert replay filter RTL
`ifndef ADVERT_REPLAY_FILTER_CORE_MACROS_SVH
`define ADVERT_REPLAY_FILTER_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ARF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("arf assertion failed");

// Next-cycle implication, disabled while in reset
`define ARF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("arf assertion failed");

`endif

// File: sv/arf_pkg.sv
// Package: types, constants and codes of the advert replay filter
package arf_pkg;

  localparam int NODE_COUNT        = 32;
  localparam int MIN_PACKET_LENGTH = 24;
  localparam int NODE_IW           = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int CTR_W             = 32;
  localparam int CFG_IDX_W         = 3;
  localparam int CFG_DATA_W        = 16;

  localparam logic [7:0] AD_MANUFACTURER = 8'hFF;
  localparam logic [7:0] BEACON_LEN      = 8'd4;

  typedef enum logic [2:0] {
    VERD_SCAN    = 3'd0,
    VERD_WINDOW  = 3'd1,
    VERD_FOREIGN = 3'd2,
    VERD_GROUP   = 3'd3,
    VERD_RANGE   = 3'd4,
    VERD_AUTH    = 3'd5,
    VERD_REPLAY  = 3'd6,
    VERD_ACCEPT  = 3'd7
  } verdict_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GROUP_FILTER   = 3'd0,
    REG_COMPANY_CODE   = 3'd1,
    REG_PROTO_VERSION  = 3'd2,
    REG_ALARM_MASK     = 3'd3,
    REG_DOOR_TYPE_CODE = 3'd4,
    REG_DOOR_OPEN_MASK = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0]        ad_type;
    logic [7:0]        ad_len;
    logic [15:0]       maker_id;
    logic [7:0]        proto_version;
    logic [15:0]       group_id;
    logic [7:0]        node_id;
    logic [7:0]        node_kind;
    logic [CTR_W-1:0]  counter;
    logic              auth_ok;
    logic [7:0]        flags;
    logic signed [7:0] signal_strength;
  } item_t;

  typedef struct packed {
    verdict_t          verdict;
    logic              stop_parsing;
    logic              alarm;
    logic              first_heard;
    logic [7:0]        node_out;
    logic [7:0]        type_out;
    logic signed [7:0] strength_out;
  } res_t;

  typedef struct packed {
    logic [15:0] group_filter;
    logic [15:0] company_code;
    logic [7:0]  protocol_version;
    logic [7:0]  alarm_mask;
    logic [7:0]  door_type_code;
    logic [7:0]  door_open_mask;
  } cfg_t;

  // Counter table update from the check stage
  typedef struct packed {
    logic               wr;
    logic [NODE_IW-1:0] idx;
    logic [CTR_W-1:0]   ctr;
  } upd_t;

endpackage

// File: sv/arf_ifs.sv
// Channel interfaces: input items, results and configuration writes
interface arf_in_if;
  import arf_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface arf_out_if;
  import arf_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface arf_cfg_if;
  import arf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: sv/arf_ram.sv
// Generic single-write, single-read RAM with registered read data
module arf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    // read-first: a same-edge write is not seen
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: sv/arf_classify.sv
// Check stage: classifies one structure against config and the stored counter
module arf_classify (
  input  arf_pkg::item_t            item,
  input  arf_pkg::cfg_t             cfg,
  input  logic [arf_pkg::CTR_W-1:0] stored_ctr,
  input  logic                      stored_vld,
  output arf_pkg::res_t             res,
  output arf_pkg::upd_t             upd
);
  import arf_pkg::*;

  logic     is_mfr;
  logic     is_beacon;
  logic     is_long;
  logic     in_range;
  logic     alarm_hit;
  verdict_t verdict;

  always_comb begin
    is_mfr    = (item.ad_type == AD_MANUFACTURER);
    is_beacon = is_mfr && (item.ad_len == BEACON_LEN);
    is_long   = is_mfr && (item.ad_len >= 8'(MIN_PACKET_LENGTH));
    in_range  = ({1'b0, item.node_id} < 9'(NODE_COUNT));
    alarm_hit = ((item.flags & cfg.alarm_mask) != 8'd0) ||
                ((item.node_kind == cfg.door_type_code) &&
                 ((item.flags & cfg.door_open_mask) != 8'd0));

    verdict = VERD_SCAN;
    if (is_beacon) begin
      verdict = (item.maker_id == cfg.company_code) ? VERD_WINDOW : VERD_FOREIGN;
    end else if (is_long) begin
      if (item.maker_id != cfg.company_code ||
          item.proto_version != cfg.protocol_version) begin
        verdict = VERD_SCAN;
      end else if (cfg.group_filter != 16'd0 && item.group_id != cfg.group_filter) begin
        verdict = VERD_GROUP;
      end else if (!in_range) begin
        verdict = VERD_RANGE;
      end else if (!item.auth_ok) begin
        verdict = VERD_AUTH;
      end else if (stored_vld && item.counter <= stored_ctr) begin
        verdict = VERD_REPLAY;
      end else begin
        verdict = VERD_ACCEPT;
      end
    end

    res.verdict      = verdict;
    res.stop_parsing = (verdict != VERD_SCAN);
    res.alarm        = (verdict == VERD_ACCEPT) && alarm_hit;
    res.first_heard  = (verdict == VERD_ACCEPT) && !stored_vld;
    res.node_out     = 8'd0;
    res.type_out     = 8'd0;
    res.strength_out = 8'sd0;
    if (verdict == VERD_WINDOW || verdict == VERD_ACCEPT) begin
      res.node_out = item.node_id;
      res.type_out = item.node_kind;
    end
    if (verdict == VERD_ACCEPT) begin
      res.strength_out = item.signal_strength;
    end

    upd.wr  = (verdict == VERD_ACCEPT);
    upd.idx = item.node_id[NODE_IW-1:0];
    upd.ctr = item.counter;
  end

endmodule

// File: sv/advert_replay_filter_core.sv
// Top level: advert classifier and per-node anti-replay counter table
//
//  channel | dir | handshake     | payload
//  in_ch   | in  | valid/ready   | item_t (parsed structure header and verdict inputs)
//  out_ch  | out | valid/ready   | res_t  (verdict, flags, node, type, strength)
//  cfg_ch  | in  | valid/ready   | index (3 bit), data (16 bit)
//
// An item passes from accept to result through the counter RAM read, which is
// registered with the item, then the check, which loads the output register and
// writes the RAM back. A new item is taken every cycle while the output drains;
// a write from the previous item is forwarded past the RAM read.
// Reset clears config, node heard bits and valid flags; RAM needs no clearing.
// A stalled output holds the check stage and then the input.
module advert_replay_filter_core (
  input logic      clk,
  input logic      rst_n,
  arf_in_if.sink   in_ch,
  arf_out_if.source out_ch,
  arf_cfg_if.sink  cfg_ch
);
  import arf_pkg::*;
  `include "advert_replay_filter_core_macros.svh"

  cfg_t                cfg_r;
  logic [NODE_COUNT-1:0] heard_r;
  item_t               s1_item_r;
  logic                s1_vld_r;
  res_t                out_res_r;
  logic                out_vld_r;
  logic                fwd_vld_r;
  logic [NODE_IW-1:0]  fwd_idx_r;
  logic [CTR_W-1:0]    fwd_ctr_r;

  logic               in_acc;
  logic               s1_adv;
  logic [CTR_W-1:0]   ram_rd;
  logic [CTR_W-1:0]   stored_ctr;
  logic [NODE_IW-1:0] s1_idx;
  res_t               res;
  upd_t               upd;
  upd_t               upd_gated;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_GROUP_FILTER:   cfg_r.group_filter     <= cfg_ch.data;
        REG_COMPANY_CODE:   cfg_r.company_code     <= cfg_ch.data;
        REG_PROTO_VERSION:  cfg_r.protocol_version <= cfg_ch.data[7:0];
        REG_ALARM_MASK:     cfg_r.alarm_mask       <= cfg_ch.data[7:0];
        REG_DOOR_TYPE_CODE: cfg_r.door_type_code   <= cfg_ch.data[7:0];
        REG_DOOR_OPEN_MASK: cfg_r.door_open_mask   <= cfg_ch.data[7:0];
        default: ;
      endcase
    end
  end

  assign s1_adv      = s1_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !s1_vld_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign s1_idx      = s1_item_r.node_id[NODE_IW-1:0];

  assign upd_gated.wr  = upd.wr && s1_adv;
  assign upd_gated.idx = upd.idx;
  assign upd_gated.ctr = upd.ctr;

  arf_ram #(
    .WIDTH(CTR_W),
    .DEPTH(NODE_COUNT)
  ) u_ctr_ram (
    .clk     (clk),
    .wr_en   (upd_gated.wr),
    .wr_addr (upd_gated.idx),
    .wr_data (upd_gated.ctr),
    .rd_en   (in_acc),
    .rd_addr (in_ch.data.node_id[NODE_IW-1:0]),
    .rd_data (ram_rd)
  );

  // forward the last write: it may have landed on the edge of this read
  assign stored_ctr = (fwd_vld_r && fwd_idx_r == s1_idx) ? fwd_ctr_r : ram_rd;

  arf_classify u_classify (
    .item       (s1_item_r),
    .cfg        (cfg_r),
    .stored_ctr (stored_ctr),
    .stored_vld (heard_r[s1_idx]),
    .res        (res),
    .upd        (upd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      heard_r   <= '0;
      fwd_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
      if (upd_gated.wr) begin
        heard_r[upd_gated.idx] <= 1'b1;
        fwd_vld_r              <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_ch.data;
    end
    if (s1_adv) begin
      out_res_r <= res;
    end
    if (upd_gated.wr) begin
      fwd_idx_r <= upd_gated.idx;
      fwd_ctr_r <= upd_gated.ctr;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_res_r;

  `ARF_ASSERT_IMPL(a_wr_only_on_accept, upd_gated.wr, s1_vld_r && res.verdict == VERD_ACCEPT)
  `ARF_ASSERT_NEXT(a_heard_after_wr, upd_gated.wr, heard_r[$past(upd_gated.idx)] && fwd_vld_r)
  `ARF_ASSERT_IMPL(a_hold_on_stall, s1_vld_r && out_vld_r && !out_ch.ready, !in_ch.ready)
  `ARF_ASSERT_IMPL(a_first_is_accept, out_vld_r && out_res_r.first_heard, out_res_r.verdict == VERD_ACCEPT)

endmodule
